/* rtl/rhc_pkg.sv */
// Shared constants and types of the RGB/HSL colour converter.
package rhc_pkg;

   localparam int COLOR_BITS = 8;
   localparam int FRAC_BITS  = 12;
   localparam int CMAX       = (1 << COLOR_BITS) - 1;
   localparam int ONE        = 1 << FRAC_BITS;
   localparam int SECTOR     = 960;
   localparam int HUE_FULL   = 5760;

   // Divider lane geometry: numerator, divisor and quotient widths.
   localparam int DIV_NUM_W = 22;
   localparam int DIV_DEN_W = 10;
   localparam int DIV_Q_W   = 13;

   // Latency of the reverse path inside its module.
   localparam int REV_LAT = 6;

   localparam logic [1:0] SEC_RED   = 2'd0;
   localparam logic [1:0] SEC_GREEN = 2'd1;
   localparam logic [1:0] SEC_BLUE  = 2'd2;

   typedef struct packed {
      logic       valid;
      logic       mode;
      logic [1:0] sector;
      logic       neg;
      logic       czero;
   } side_type;

endpackage

/* rtl/rhc_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
module rhc_div #(
   parameter int NUM_W = 22,
   parameter int DEN_W = 10,
   parameter int Q_W   = 13
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo
);

   localparam int SW = DEN_W + Q_W;

   logic [SW-1:0]    rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];

   for (genvar i = 0; i < Q_W; i++) begin : g_stage
      localparam int B = Q_W - 1 - i;
      logic [SW-1:0]    rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [Q_W-1:0]   quo_prev;
      logic [SW-1:0]    shifted;
      logic [SW-1:0]    rem_in;
      logic [Q_W-1:0]   quo_in;

      if (i == 0) begin : g_first
         assign rem_prev = SW'(num);
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
      end

      assign shifted = SW'(den_prev) << B;

      always_comb begin
         rem_in = rem_prev;
         quo_in = quo_prev;
         if (rem_prev >= shifted) begin
            rem_in = rem_prev - shifted;
            quo_in = quo_prev | (Q_W'(1) << B);
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         den_ff[i] <= den_prev;
         quo_ff[i] <= quo_in;
      end
   end

   assign quo = quo_ff[Q_W-1];

endmodule

/* rtl/rhc_rev.sv */
// Six-stage HSL to RGB datapath with rounding and clamping.
module rhc_rev
   import rhc_pkg::*;
(
   input  logic        clock,
   input  logic [12:0] hue_in,
   input  logic [12:0] sat_in,
   input  logic [12:0] light_in,
   output logic [7:0]  red_out,
   output logic [7:0]  green_out,
   output logic [7:0]  blue_out
);

   localparam logic [45:0] REV_SCALE = 46'(2 * SECTOR) << (2 * FRAC_BITS);
   localparam int          REV_SHIFT = 2 * FRAC_BITS + 8;
   localparam logic [26:0] RECIP15   = 27'd4370;

   // Stage 1: wrap and clamp, split the hue into sector and offset.
   logic [12:0] hh, ll1_in, ss1_in, om1_in, ll1_ff, ss1_ff, om1_ff;
   logic [13:0] span;
   logic [2:0]  k1_in, k1_ff;
   logic [12:0] f;
   logic [9:0]  ft1_in, ft1_ff;

   always_comb begin
      hh     = (hue_in >= 13'(HUE_FULL)) ? hue_in - 13'(HUE_FULL) : hue_in;
      ss1_in = (sat_in > 13'(ONE)) ? 13'(ONE) : sat_in;
      ll1_in = (light_in > 13'(ONE)) ? 13'(ONE) : light_in;
      span   = ({ll1_in, 1'b0} >= 14'(ONE)) ? {ll1_in, 1'b0} - 14'(ONE)
                                            : 14'(ONE) - {ll1_in, 1'b0};
      om1_in = 13'(14'(ONE) - span);
      priority if (hh < 13'(SECTOR))     k1_in = 3'd0;
      else if (hh < 13'(2 * SECTOR))     k1_in = 3'd1;
      else if (hh < 13'(3 * SECTOR))     k1_in = 3'd2;
      else if (hh < 13'(4 * SECTOR))     k1_in = 3'd3;
      else if (hh < 13'(5 * SECTOR))     k1_in = 3'd4;
      else                               k1_in = 3'd5;
      f      = hh - 13'(k1_in) * 13'(SECTOR);
      ft1_in = k1_in[0] ? 10'(13'(SECTOR) - f) : 10'(f);
   end

   always_ff @(posedge clock) begin
      ll1_ff <= ll1_in;
      ss1_ff <= ss1_in;
      om1_ff <= om1_in;
      k1_ff  <= k1_in;
      ft1_ff <= ft1_in;
   end

   // Stage 2: chroma at scale ONE squared.
   logic [24:0] cw2_ff;
   logic [12:0] ll2_ff;
   logic [2:0]  k2_ff;
   logic [9:0]  ft2_ff;
   logic [25:0] cw_prod;

   assign cw_prod = 26'(om1_ff) * 26'(ss1_ff);

   always_ff @(posedge clock) begin
      cw2_ff <= cw_prod[24:0];
      ll2_ff <= ll1_ff;
      k2_ff  <= k1_ff;
      ft2_ff <= ft1_ff;
   end

   // Stage 3: the chroma, ramp and base terms.
   logic [34:0]        cs3_in, cs3_ff;
   logic [35:0]        xs3_in, xs3_ff;
   logic signed [36:0] ms3_in, ms3_ff;
   logic [2:0]         k3_ff;
   logic [34:0]        xprod, lterm, cterm;

   always_comb begin
      xprod  = 35'(cw2_ff) * 35'(ft2_ff);
      xs3_in = {xprod, 1'b0};
      cs3_in = 35'(cw2_ff) * 35'(2 * SECTOR);
      lterm  = (35'(ll2_ff) * 35'(2 * SECTOR)) << FRAC_BITS;
      cterm  = 35'(cw2_ff) * 35'(SECTOR);
      ms3_in = $signed({2'b00, lterm}) - $signed({2'b00, cterm});
   end

   always_ff @(posedge clock) begin
      cs3_ff <= cs3_in;
      xs3_ff <= xs3_in;
      ms3_ff <= ms3_in;
      k3_ff  <= k2_ff;
   end

   // Stage 4: per-channel sums selected by sector.
   logic signed [36:0] v4_in [3];
   logic signed [36:0] v4_ff [3];
   logic signed [36:0] cs_s, xs_s;

   always_comb begin
      cs_s = $signed({2'b00, cs3_ff});
      xs_s = $signed({1'b0, xs3_ff});
      v4_in[0] = ms3_ff;
      v4_in[1] = ms3_ff;
      v4_in[2] = ms3_ff;
      unique case (k3_ff)
         3'd0: begin
            v4_in[0] = ms3_ff + cs_s;
            v4_in[1] = ms3_ff + xs_s;
         end
         3'd1: begin
            v4_in[0] = ms3_ff + xs_s;
            v4_in[1] = ms3_ff + cs_s;
         end
         3'd2: begin
            v4_in[1] = ms3_ff + cs_s;
            v4_in[2] = ms3_ff + xs_s;
         end
         3'd3: begin
            v4_in[1] = ms3_ff + xs_s;
            v4_in[2] = ms3_ff + cs_s;
         end
         3'd4: begin
            v4_in[0] = ms3_ff + xs_s;
            v4_in[2] = ms3_ff + cs_s;
         end
         default: begin
            v4_in[0] = ms3_ff + cs_s;
            v4_in[2] = ms3_ff + xs_s;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) v4_ff[c] <= v4_in[c];
   end

   // Stage 5: scale to the colour range; the divisor is fifteen times a power of two.
   logic [13:0] t5_in [3];
   logic [13:0] t5_ff [3];
   logic        p5_in [3];
   logic        p5_ff [3];
   logic [45:0] num5  [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         p5_in[c] = !v4_ff[c][36] && (v4_ff[c] != '0);
         num5[c]  = 46'(v4_ff[c][35:0]) * 46'(2 * CMAX) + REV_SCALE;
         t5_in[c] = num5[c][REV_SHIFT+13:REV_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         t5_ff[c] <= t5_in[c];
         p5_ff[c] <= p5_in[c];
      end
   end

   // Stage 6: divide by fifteen through a reciprocal, then clamp.
   logic [7:0]  c6_in [3];
   logic [7:0]  c6_ff [3];
   logic [26:0] rprod [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rprod[c] = 27'(t5_ff[c]) * RECIP15;
         if (!p5_ff[c])                   c6_in[c] = '0;
         else if (rprod[c][26:16] > 11'(CMAX)) c6_in[c] = 8'(CMAX);
         else                             c6_in[c] = rprod[c][23:16];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) c6_ff[c] <= c6_in[c];
   end

   assign red_out   = c6_ff[0];
   assign green_out = c6_ff[1];
   assign blue_out  = c6_ff[2];

endmodule

/* rtl/rgb_hsl_convert.sv */
// Top level of the pipelined RGB/HSL colour converter.
//
//   Channel   Handshake             Payload
//   request   start / busy          req_mode, req_red_in .. req_light_in
//   response  rsp_valid (strobe)    rsp_red_out .. rsp_light_out
//
// A word is taken on every clock edge with start high and busy low, so one
// pixel can enter each cycle. Its result is on the response ports for a single
// cycle, marked by rsp_valid, after the prepare stage, the thirteen stages of
// the hue and saturation divider lanes (one quotient bit each) and the output
// register. busy is high while reset is held and in the cycle after it, while
// the pipeline valid bits come out cleared. The receiver cannot stall, so the
// pipeline never halts.
module rgb_hsl_convert
   import rhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   input  logic [12:0] req_hue_in,
   input  logic [12:0] req_sat_in,
   input  logic [12:0] req_light_in,
   output logic        rsp_valid,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic [12:0] rsp_hue_out,
   output logic [12:0] rsp_sat_out,
   output logic [12:0] rsp_light_out
);

   localparam int PIPE    = DIV_Q_W + 1;
   localparam int RGB_DLY = PIPE - REV_LAT;
   localparam logic [20:0] RECIP255 = 21'd1052689;

   logic busy_ff, busy_in;
   logic accept;

   assign busy_in = reset;
   assign busy    = busy_ff;
   assign accept  = start && !busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   // Prepare stage: extremes, chroma, sector and the three division operands.
   logic [7:0]  mx, mn, cc, mag;
   logic [8:0]  sum, den9;
   logic signed [8:0] diff;
   side_type    side_in;
   logic [DIV_NUM_W-1:0] l_num_in, s_num_in, h_num_in;
   logic [DIV_DEN_W-1:0] s_den_in, h_den_in;
   logic [DIV_NUM_W-1:0] l_num_ff, s_num_ff, h_num_ff;
   logic [DIV_DEN_W-1:0] s_den_ff, h_den_ff;
   logic [1:0]  sector;
   logic [18:0] mag_scaled;

   always_comb begin
      mx = req_red_in;
      mn = req_red_in;
      if (req_green_in > mx) mx = req_green_in;
      if (req_blue_in > mx)  mx = req_blue_in;
      if (req_green_in < mn) mn = req_green_in;
      if (req_blue_in < mn)  mn = req_blue_in;
      cc   = mx - mn;
      sum  = 9'(mx) + 9'(mn);
      den9 = (sum < 9'(2 * CMAX) - sum) ? sum : 9'(2 * CMAX) - sum;
      // Red wins ties over green, green over blue.
      priority if (mx == req_red_in) begin
         sector = SEC_RED;
         diff   = $signed({1'b0, req_green_in}) - $signed({1'b0, req_blue_in});
      end else if (mx == req_green_in) begin
         sector = SEC_GREEN;
         diff   = $signed({1'b0, req_blue_in}) - $signed({1'b0, req_red_in});
      end else begin
         sector = SEC_BLUE;
         diff   = $signed({1'b0, req_red_in}) - $signed({1'b0, req_green_in});
      end
      mag        = diff[8] ? 8'(-diff) : diff[7:0];
      mag_scaled = (19'(mag) << 11) - (19'(mag) << 7) + 19'(cc);
      // Lightness is round(sum * 4096 / 510); dividing numerator and divisor
      // by two leaves floor((sum * 2048 + 127) / 255).
      l_num_in   = (DIV_NUM_W'(sum) << (FRAC_BITS - 1)) + DIV_NUM_W'(CMAX / 2);
      s_num_in   = (DIV_NUM_W'(cc) << (FRAC_BITS + 1)) + DIV_NUM_W'(den9);
      s_den_in   = DIV_DEN_W'({den9, 1'b0});
      h_num_in   = DIV_NUM_W'(mag_scaled);
      h_den_in   = DIV_DEN_W'({cc, 1'b0});

      side_in.valid  = accept;
      side_in.mode   = req_mode;
      side_in.sector = sector;
      side_in.neg    = diff[8];
      side_in.czero  = (cc == '0);
   end

   always_ff @(posedge clock) begin
      l_num_ff <= l_num_in;
      s_num_ff <= s_num_in;
      s_den_ff <= s_den_in;
      h_num_ff <= h_num_in;
      h_den_ff <= h_den_in;
   end

   // Control travels alongside the data; only the valid bits need reset.
   side_type side_ff [PIPE];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE; i++) side_ff[i] <= '0;
      end else begin
         side_ff[0] <= side_in;
         for (int i = 1; i < PIPE; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // Saturation and hue each have a divider lane of their own.
   logic [DIV_Q_W-1:0] l_quo, s_quo, h_quo;

   // Lightness divides by a constant, so a reciprocal multiply takes it and a
   // short delay line brings it level with the two divider lanes.
   logic [42:0]        l_prod;
   logic [DIV_Q_W-1:0] l_q_ff [DIV_Q_W];

   assign l_prod = 43'(l_num_ff) * 43'(RECIP255);

   always_ff @(posedge clock) begin
      l_q_ff[0] <= l_prod[28 +: DIV_Q_W];
      for (int i = 1; i < DIV_Q_W; i++) l_q_ff[i] <= l_q_ff[i-1];
   end

   assign l_quo = l_q_ff[DIV_Q_W-1];

   rhc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_div_sat (
      .clock (clock),
      .num   (s_num_ff),
      .den   (s_den_ff),
      .quo   (s_quo)
   );

   rhc_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W), .Q_W(DIV_Q_W)) u_div_hue (
      .clock (clock),
      .num   (h_num_ff),
      .den   (h_den_ff),
      .quo   (h_quo)
   );

   // The reverse direction runs beside the dividers and is delayed to match.
   logic [7:0]  rev_r, rev_g, rev_b;
   logic [23:0] rgbd_ff [RGB_DLY];

   rhc_rev u_rev (
      .clock     (clock),
      .hue_in    (req_hue_in),
      .sat_in    (req_sat_in),
      .light_in  (req_light_in),
      .red_out   (rev_r),
      .green_out (rev_g),
      .blue_out  (rev_b)
   );

   always_ff @(posedge clock) begin
      rgbd_ff[0] <= {rev_r, rev_g, rev_b};
      for (int i = 1; i < RGB_DLY; i++) rgbd_ff[i] <= rgbd_ff[i-1];
   end

   // Output stage: place the hue in its sector and blank the unused fields.
   side_type    last;
   logic [13:0] hue_w;
   logic [13:0] hue_base;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  r_ff, g_ff, b_ff, r_in, g_in, b_in;
   logic [12:0] h_ff, s_ff, l_ff, h_in, s_in, l_in;

   assign last = side_ff[PIPE-1];

   always_comb begin
      unique case (last.sector)
         SEC_RED:   hue_base = '0;
         SEC_GREEN: hue_base = 14'(2 * SECTOR);
         default:   hue_base = 14'(4 * SECTOR);
      endcase
      if (last.neg) begin
         hue_w = hue_base - 14'(h_quo);
         if (last.sector == SEC_RED) hue_w = 14'(HUE_FULL) - 14'(h_quo);
      end else begin
         hue_w = hue_base + 14'(h_quo);
      end
      if (hue_w >= 14'(HUE_FULL)) hue_w = hue_w - 14'(HUE_FULL);

      rsp_valid_in = last.valid;
      r_in = '0;
      g_in = '0;
      b_in = '0;
      h_in = '0;
      s_in = '0;
      l_in = '0;
      if (last.mode) begin
         {r_in, g_in, b_in} = rgbd_ff[RGB_DLY-1];
      end else begin
         l_in = l_quo;
         if (!last.czero) begin
            h_in = hue_w[12:0];
            s_in = s_quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff <= r_in;
      g_ff <= g_in;
      b_ff <= b_in;
      h_ff <= h_in;
      s_ff <= s_in;
      l_ff <= l_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = r_ff;
   assign rsp_green_out = g_ff;
   assign rsp_blue_out  = b_ff;
   assign rsp_hue_out   = h_ff;
   assign rsp_sat_out   = s_ff;
   assign rsp_light_out = l_ff;

endmodule

/* rtl/rhc_chk.sv */
// Port-level checks of the colour converter, bound to its top level.
module rhc_chk
   import rhc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_mode,
   input logic [7:0]  req_red_in,
   input logic [7:0]  req_green_in,
   input logic [7:0]  req_blue_in,
   input logic [12:0] req_hue_in,
   input logic [12:0] req_sat_in,
   input logic [12:0] req_light_in,
   input logic        rsp_valid,
   input logic [7:0]  rsp_red_out,
   input logic [7:0]  rsp_green_out,
   input logic [7:0]  rsp_blue_out,
   input logic [12:0] rsp_hue_out,
   input logic [12:0] rsp_sat_out,
   input logic [12:0] rsp_light_out
);

   // Every result stems from a word that the converter took earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 15))
      else $error("result without a matching request");

   // Hue, saturation and lightness stay within their ranges.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue_out < 13'(HUE_FULL)) && (rsp_sat_out <= 13'(ONE))
                    && (rsp_light_out <= 13'(ONE)))
      else $error("hsl result out of range");

   // Only one direction's fields carry data in a result.
   a_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_red_out | rsp_green_out | rsp_blue_out) == '0)
                 || ((rsp_hue_out | rsp_sat_out | rsp_light_out) == '0))
      else $error("both directions present in one result");

   // No word is taken in the cycle after reset.
   a_reset_busy: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("busy low straight after reset");

endmodule

bind rgb_hsl_convert rhc_chk u_rhc_chk (.*);

/* verif/tb.sv */
// Self-checking testbench of the RGB/HSL colour converter.
`timescale 1ns / 100ps

module tb;
   import rhc_pkg::*;

   // A result word as the converter reports it.
   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [12:0] hue;
      logic [12:0] sat;
      logic [12:0] light;
   } pixel_out_type;

   // One row of the directed table; has_exp marks a result typed in by hand.
   typedef struct {
      logic          mode;
      logic [7:0]    r, g, b;
      logic [12:0]   h, s, l;
      bit            has_exp;
      pixel_out_type exp;
   } stim_row_type;

   localparam int LIMIT_CYCLES = 200000;
   localparam int DRAIN_CYCLES = 40;

   logic        clock, reset, start, busy;
   logic        req_mode;
   logic [7:0]  req_red_in, req_green_in, req_blue_in;
   logic [12:0] req_hue_in, req_sat_in, req_light_in;
   logic        rsp_valid;
   logic [7:0]  rsp_red_out, rsp_green_out, rsp_blue_out;
   logic [12:0] rsp_hue_out, rsp_sat_out, rsp_light_out;

   pixel_out_type pending_pixels[$];
   int            errors = 0;
   int            cycle_count = 0;
   int            idle_pct = 0;

   rgb_hsl_convert uut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Rounded division, ties upward.
   function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
      return (num * 2 + den) / (den * 2);
   endfunction

   // Scales one fixed-point channel value back to an 8-bit colour, clamped.
   function automatic logic [7:0] scale_channel(longint v, longint unsigned scale);
      longint unsigned q;
      if (v <= 0) return 8'd0;
      q = rdiv(longint'(v) * CMAX, scale);
      return (q > CMAX) ? 8'(CMAX) : 8'(q);
   endfunction

   // Hue offset within a sector, rounded to nearest with ties away from zero.
   function automatic longint hue_offset(longint diff, longint unsigned c);
      longint unsigned mag;
      longint q;
      mag = (diff < 0) ? -diff : diff;
      q = longint'(rdiv(mag * SECTOR, c));
      return (diff < 0) ? -q : q;
   endfunction

   // Computes the converted pixel for one input word.
   function automatic pixel_out_type convert_pixel(logic mode, logic [7:0] cr,
                                                   logic [7:0] cg, logic [7:0] cb,
                                                   logic [12:0] hin, logic [12:0] sin,
                                                   logic [12:0] lin);
      pixel_out_type p;
      longint unsigned mx, mn, c, sum, den, hh, ss, ll, span, cw, k, f, ft, scale;
      longint hv, cs, xs, ms, vr, vg, vb;
      p = '0;
      if (!mode) begin
         mx = cr; mn = cr;
         if (cg > mx) mx = cg;
         if (cb > mx) mx = cb;
         if (cg < mn) mn = cg;
         if (cb < mn) mn = cb;
         c = mx - mn;
         sum = mx + mn;
         p.light = 13'(rdiv(sum * ONE, 2 * CMAX));
         // A grey pixel keeps hue and saturation at zero.
         if (c != 0) begin
            den = (sum < 2 * CMAX - sum) ? sum : 2 * CMAX - sum;
            p.sat = 13'(rdiv(c * ONE, den));
            if (mx == cr) begin
               hv = hue_offset(longint'(cg) - longint'(cb), c);
               if (hv < 0) hv += HUE_FULL;
            end else if (mx == cg) begin
               hv = hue_offset(longint'(cb) - longint'(cr), c) + 2 * SECTOR;
            end else begin
               hv = hue_offset(longint'(cr) - longint'(cg), c) + 4 * SECTOR;
            end
            if (hv >= HUE_FULL) hv -= HUE_FULL;
            p.hue = 13'(hv);
         end
      end else begin
         hh = hin; ss = sin; ll = lin;
         if (hh >= HUE_FULL) hh -= HUE_FULL;
         if (ss > ONE) ss = ONE;
         if (ll > ONE) ll = ONE;
         span = (2 * ll >= ONE) ? 2 * ll - ONE : ONE - 2 * ll;
         cw = (ONE - span) * ss;
         k = hh / SECTOR;
         f = hh % SECTOR;
         ft = k[0] ? SECTOR - f : f;
         scale = longint'(ONE) * ONE * 2 * SECTOR;
         cs = cw * 2 * SECTOR;
         xs = cw * 2 * ft;
         ms = longint'(ll * ONE * 2 * SECTOR) - longint'(cw * SECTOR);
         vr = ms; vg = ms; vb = ms;
         case (k)
            0: begin vr += cs; vg += xs; end
            1: begin vr += xs; vg += cs; end
            2: begin vg += cs; vb += xs; end
            3: begin vg += xs; vb += cs; end
            4: begin vr += xs; vb += cs; end
            default: begin vr += cs; vb += xs; end
         endcase
         p.red = scale_channel(vr, scale);
         p.green = scale_channel(vg, scale);
         p.blue = scale_channel(vb, scale);
      end
      return p;
   endfunction

   // Hands one word to the converter, idling first at the current rate, and
   // queues its expected result. Called just after a falling edge; start is
   // left high so that the next word can follow without a gap.
   task automatic send_word(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [12:0] h, logic [12:0] s, logic [12:0] l,
                            bit has_exp, pixel_out_type exp);
      pixel_out_type p;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_red_in <= r; req_green_in <= g; req_blue_in <= b;
      req_hue_in <= h; req_sat_in <= s; req_light_in <= l;
      do @(posedge clock); while (busy);
      p = convert_pixel(mode, r, g, b, h, s, l);
      if (has_exp && p !== exp) begin
         // The hand-typed figure disagrees with the predictor: flag it too.
         $display("%0t: table row mismatch expected %h actual %h", $time, exp, p);
         errors++;
      end
      pending_pixels.push_back(has_exp ? exp : p);
      @(negedge clock);
   endtask

   // Result checker: every strobe must meet the oldest expectation.
   always @(posedge clock) begin
      pixel_out_type got, want;
      if (!reset && rsp_valid) begin
         got = '{rsp_red_out, rsp_green_out, rsp_blue_out,
                 rsp_hue_out, rsp_sat_out, rsp_light_out};
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
         end else begin
            want = pending_pixels.pop_front();
            if (got.red !== want.red)
               $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
            if (got.green !== want.green)
               $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
            if (got.blue !== want.blue)
               $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
            if (got.hue !== want.hue)
               $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
            if (got.sat !== want.sat)
               $display("%0t: sat expected %0d actual %0d", $time, want.sat, got.sat);
            if (got.light !== want.light)
               $display("%0t: light expected %0d actual %0d", $time, want.light, got.light);
            if (got !== want) errors++;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   stim_row_type rows[$];

   // Appends one row to the directed table.
   function automatic void add_row(logic m, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [12:0] h, logic [12:0] s, logic [12:0] l,
                                   bit he, pixel_out_type e);
      stim_row_type row;
      row.mode = m; row.r = r; row.g = g; row.b = b;
      row.h = h; row.s = s; row.l = l; row.has_exp = he; row.exp = e;
      rows.push_back(row);
   endfunction

   initial begin
      int n;
      logic [7:0] rr, gg, bb;
      start = 1'b0; reset = 1'b1; req_mode = 1'b0;
      req_red_in = '0; req_green_in = '0; req_blue_in = '0;
      req_hue_in = '0; req_sat_in = '0; req_light_in = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed table. Black, white and pure red can be read off directly in
      // both directions; the remaining rows cover sector ties, the red wrap and the
      // clamps of the reverse direction, and go to the predictor.
      add_row(0, 8'd0, 8'd0, 8'd0, '0, '0, '0, 1, '0);
      add_row(0, 8'd255, 8'd255, 8'd255, 13'h1fff, 13'h1fff, 13'h1fff, 1,
              '{8'd0, 8'd0, 8'd0, 13'd0, 13'd0, 13'd4096});
      add_row(0, 8'd255, 8'd0, 8'd0, '0, '0, '0, 1,
              '{8'd0, 8'd0, 8'd0, 13'd0, 13'd4096, 13'd2048});
      add_row(0, 8'd255, 8'd0, 8'd1, '0, '0, '0, 0, '0);     // red wrap below zero
      add_row(0, 8'd255, 8'd255, 8'd0, '0, '0, '0, 0, '0);   // red and green tie
      add_row(0, 8'd0, 8'd255, 8'd255, '0, '0, '0, 0, '0);   // green and blue tie
      add_row(0, 8'd0, 8'd0, 8'd255, '0, '0, '0, 0, '0);
      add_row(0, 8'd1, 8'd0, 8'd0, '0, '0, '0, 0, '0);
      add_row(0, 8'd254, 8'd255, 8'd255, '0, '0, '0, 0, '0);
      add_row(0, 8'd128, 8'd128, 8'd128, '0, '0, '0, 0, '0); // grey
      add_row(1, '0, '0, '0, 13'd0, 13'd0, 13'd0, 1, '0);
      add_row(1, 8'hff, 8'hff, 8'hff, 13'd0, 13'd4096, 13'd4096, 1,
              '{8'd255, 8'd255, 8'd255, 13'd0, 13'd0, 13'd0});
      add_row(1, '0, '0, '0, 13'd0, 13'd4096, 13'd2048, 1,
              '{8'd255, 8'd0, 8'd0, 13'd0, 13'd0, 13'd0});
      add_row(1, '0, '0, '0, 13'd5759, 13'd4096, 13'd2048, 0, '0);
      add_row(1, '0, '0, '0, 13'd5760, 13'd4096, 13'd2048, 0, '0); // hue wraps once
      add_row(1, '0, '0, '0, 13'h1fff, 13'h1fff, 13'h1fff, 0, '0); // hue wraps, saturation and lightness clamp
      add_row(1, '0, '0, '0, 13'd960, 13'd4097, 13'd1000, 0, '0);
      add_row(1, '0, '0, '0, 13'd1920, 13'd3000, 13'd2048, 0, '0);
      add_row(1, '0, '0, '0, 13'd2880, 13'd4096, 13'd3000, 0, '0);
      add_row(1, '0, '0, '0, 13'd3840, 13'd2048, 13'd2048, 0, '0);
      add_row(1, '0, '0, '0, 13'd4800, 13'd4096, 13'd1, 0, '0);
      foreach (rows[i])
         send_word(rows[i].mode, rows[i].r, rows[i].g, rows[i].b,
                   rows[i].h, rows[i].s, rows[i].l, rows[i].has_exp, rows[i].exp);
      start <= 1'b0;

      // Pause until the pipeline has drained completely once.
      while (pending_pixels.size() != 0) @(negedge clock);

      // Random part in idling phases; the receiver has no stall of its own.
      for (n = 0; n < 1700; n++) begin
         case (n / 425)
            0: idle_pct = 0;
            1: idle_pct = 66;
            2: idle_pct = 15;
            default: idle_pct = (n % 100 < 50) ? 0 : 66;
         endcase
         rr = 8'($urandom); gg = 8'($urandom); bb = 8'($urandom);
         // Now and then force ties or greys so the sector rules get exercised.
         case ($urandom_range(7))
            0: gg = rr;
            1: bb = gg;
            2: begin gg = rr; bb = rr; end
            default: ;
         endcase
         if ($urandom_range(1))
            send_word(1'b0, rr, gg, bb, 13'($urandom), 13'($urandom), 13'($urandom), 0, '0);
         else if ($urandom_range(9) == 0)
            send_word(1'b1, rr, gg, bb, 13'($urandom), 13'($urandom), 13'($urandom), 0, '0);
         else
            send_word(1'b1, rr, gg, bb, 13'($urandom_range(5759)),
                      13'($urandom_range(4096)), 13'($urandom_range(4096)), 0, '0);
      end
      start <= 1'b0;

      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
